// ----- rtl/core/grid_astar_path_search_assert.svh -----
// Assertion macros for the grid path search block.
// Used inside modules that have clk and arst_n in scope; no other dependencies.
`ifndef GRID_ASTAR_PATH_SEARCH_ASSERT_SVH
`define GRID_ASTAR_PATH_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied
`define GAPS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is applied
`define GAPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/gaps_pkg.sv -----
// Types, constants and helper functions of the grid path search block.
// No dependencies; imported by grid_astar_path_search.
package gaps_pkg;

	localparam int MAX_CELLS = 4096;
	localparam int CELL_W    = $clog2(MAX_CELLS);
	localparam int LEN_W     = CELL_W + 1;
	localparam int SIDE_W    = 7;
	localparam int RC_W      = 6;
	localparam int CFG_IDX_W = 1;
	localparam int OP_W      = 2;
	localparam int COST_W    = 16;
	localparam int F_W       = 17;
	localparam int H_W       = 11;
	localparam int NB_W      = 3;
	localparam int DIV_CNT_W = $clog2(CELL_W);

	localparam logic [SIDE_W-1:0] SIDE_MAX       = 7'd64;
	localparam logic [COST_W-1:0] COST_UNREACHED = 16'hFFFF;
	localparam logic [COST_W-1:0] COST_SAT       = 16'hFFFE;
	localparam logic [COST_W-1:0] STEP_COST      = 16'd10;
	localparam logic [COST_W-1:0] DIAG_COST      = 16'd14;
	localparam logic [NB_W-1:0]   NB_LAST        = 3'd7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE  = 2'd0,
		OP_SEARCH = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_FOUND   = 2'd1,
		STAT_NO_PATH = 2'd2,
		STAT_INVALID = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_DIV, S_RANGE, S_FREE_S, S_FREE_G, S_FREE_CHK,
		S_NB_RD, S_NB_EV, S_NB_END, S_CCLR, S_SEED,
		S_POP_RD, S_POP_LAST, S_POP_TAKE, S_WALK_INIT
	} fsm_t;

	// what a neighbor sweep is for
	typedef enum logic [1:0] {
		M_CHK_GOAL, M_CHK_START, M_EXPAND, M_WALK
	} scan_mode_t;

	// one open-list slot; slots are never moved, a popped one is marked removed
	typedef struct packed {
		logic              removed;
		logic [RC_W-1:0]   row;
		logic [RC_W-1:0]   col;
		logic [COST_W-1:0] g;
		logic [F_W-1:0]    f;
	} open_ent_t;

	// row offset of neighbor k, row-major over the 3x3 window minus the center
	function automatic logic [1:0] nb_off_r(input logic [NB_W-1:0] k);
		case (k)
			3'd0, 3'd1, 3'd2: return 2'b11;
			3'd3, 3'd4:       return 2'b00;
			default:          return 2'b01;
		endcase
	endfunction

	// column offset of neighbor k
	function automatic logic [1:0] nb_off_c(input logic [NB_W-1:0] k);
		case (k)
			3'd0, 3'd3, 3'd5: return 2'b11;
			3'd1, 3'd6:       return 2'b00;
			default:          return 2'b01;
		endcase
	endfunction

	// Manhattan distance in tenths
	function automatic logic [H_W-1:0] heur(input logic [RC_W-1:0] r, c, gr, gc);
		logic [RC_W-1:0] ar;
		logic [RC_W-1:0] ac;
		logic [H_W-1:0]  s;
		ar = (r > gr) ? (r - gr) : (gr - r);
		ac = (c > gc) ? (c - gc) : (gc - c);
		s  = H_W'(ar) + H_W'(ac);
		return (s << 3) + (s << 1);
	endfunction

endpackage

// ----- rtl/core/grid_astar_path_search.sv -----
// 8-connected A* path planner over a grid of free bits, with path store.
// Depends on gaps_pkg and grid_astar_path_search_assert.svh.
//
// Channel   Signals                                         Handshake
// request   op cell_index cell_free start_cell goal_cell    start && !busy
//           path_index
// result    status path_length path_cell                    done, one cycle
// config    wr_index wr_data                                wr_en, any cycle
//
// Cell writes and path reads may come back to back; for these the result strobes
// in the cycle after the request.
// A search runs a division of start and goal by the width, range and free checks, a
// neighbor sweep each for goal and start, a clear of the cost table and a seed, then
// per popped cell a scan of the open-list slots used so far and a sweep, then a walk
// start and a sweep per path cell after the goal; a sweep steps through all eight
// neighbors and evaluates each in-grid one. After reset a pass over every cell clears
// the free map; busy is high meanwhile. The receiver cannot stall; results are never held back.
module grid_astar_path_search (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          wr_en,
	input  logic [gaps_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [gaps_pkg::SIDE_W-1:0]   wr_data,
	input  logic [gaps_pkg::OP_W-1:0]     op,
	input  logic [gaps_pkg::CELL_W-1:0]   cell_index,
	input  logic                          cell_free,
	input  logic [gaps_pkg::CELL_W-1:0]   start_cell,
	input  logic [gaps_pkg::CELL_W-1:0]   goal_cell,
	input  logic [gaps_pkg::CELL_W-1:0]   path_index,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [gaps_pkg::LEN_W-1:0]    path_length,
	output logic [gaps_pkg::CELL_W-1:0]   path_cell
);
	import gaps_pkg::*;

	// control state
	fsm_t                  state_q, state_d;
	logic [SIDE_W-1:0]     w_q, h_q, w_eff, h_eff;
	logic [LEN_W-1:0]      clr_q;
	logic                  done_q, rd_hit_q;
	status_t               status_q;
	logic [LEN_W-1:0]      stored_len_q, open_tail_q, open_live_q;

	// search operands and division
	logic [CELL_W-1:0]     start_q, goal_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic [SIDE_W-1:0]     s_rem_q, g_rem_q, s_rem_t, g_rem_t, s_rem_n, g_rem_n;
	logic [CELL_W-1:0]     s_quo_q, g_quo_q;
	logic                  s_bit, g_bit;
	logic [RC_W-1:0]       s_row_q, s_col_q, g_row_q, g_col_q;
	logic [2*SIDE_W-1:0]   cells;
	logic                  range_bad;
	logic                  free_s_q;

	// neighbor sweep
	scan_mode_t            mode_q;
	logic [RC_W-1:0]       ctr_row_q, ctr_col_q;
	logic [NB_W-1:0]       k_q;
	logic [1:0]            off_r, off_c;
	logic signed [SIDE_W:0] nr_s, nc_s;
	logic                  nb_in, nb_diag;
	logic [RC_W-1:0]       nr, nc;
	logic [2*SIDE_W-1:0]   nb_prod;
	logic [CELL_W-1:0]     nb_idx;
	logic [CELL_W-1:0]     nb_idx_q;
	logic [RC_W-1:0]       nb_row_q, nb_col_q;
	logic                  nb_diag_q;
	logic [H_W-1:0]        nb_h_q;
	logic                  nb_any_q;
	logic [CELL_W-1:0]     best_idx_q;
	logic [RC_W-1:0]       best_row_q, best_col_q;
	logic [COST_W-1:0]     best_cost_q;
	logic [COST_W-1:0]     g_cur_q;
	logic                  goal_hit_q;
	logic [LEN_W-1:0]      walk_len_q;

	// open-list scan pipeline
	logic [CELL_W-1:0]     scan_q, pidx_s1, pop_idx_q;
	logic                  pv_s1, pop_any_q, pop_take;
	open_ent_t             pop_best_q;

	// expansion arithmetic
	logic [COST_W:0]       c_sum;
	logic [COST_W-1:0]     c_new;
	logic [F_W-1:0]        f_new;
	logic                  exp_take, walk_take;

	// memories and their ports
	logic                  free_mem [MAX_CELLS];
	logic [COST_W-1:0]     cost_mem [MAX_CELLS];
	open_ent_t             open_mem [MAX_CELLS];
	logic [CELL_W-1:0]     path_mem [MAX_CELLS];
	logic                  free_rd_q;
	logic [COST_W-1:0]     cost_rd_q;
	open_ent_t             open_rd_q;
	logic [CELL_W-1:0]     path_rd_q;
	logic                  free_we, free_wdata;
	logic [CELL_W-1:0]     free_waddr, mem_raddr;
	logic                  cost_we;
	logic [CELL_W-1:0]     cost_waddr;
	logic [COST_W-1:0]     cost_wdata;
	logic                  open_we;
	logic [CELL_W-1:0]     open_waddr;
	open_ent_t             open_wdata;
	logic                  path_we;
	logic [CELL_W-1:0]     path_waddr, path_wdata, path_raddr;
	logic [LEN_W-1:0]      path_off;

	// result controls
	logic                  accept, res_en, res_hit, res_len_en;
	status_t               res_status;
	logic [LEN_W-1:0]      res_len;

	// clamp grid sides to 1..64
	assign w_eff = (w_q == '0) ? SIDE_W'(1) : ((w_q > SIDE_MAX) ? SIDE_MAX : w_q);
	assign h_eff = (h_q == '0) ? SIDE_W'(1) : ((h_q > SIDE_MAX) ? SIDE_MAX : h_q);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// one restoring-division step per cycle for start and goal
	assign s_rem_t = {s_rem_q[RC_W-1:0], s_quo_q[CELL_W-1]};
	assign g_rem_t = {g_rem_q[RC_W-1:0], g_quo_q[CELL_W-1]};
	assign s_bit   = (s_rem_t >= w_eff);
	assign g_bit   = (g_rem_t >= w_eff);
	assign s_rem_n = s_bit ? (s_rem_t - w_eff) : s_rem_t;
	assign g_rem_n = g_bit ? (g_rem_t - w_eff) : g_rem_t;

	// start/goal range checks
	assign cells     = (2*SIDE_W)'(w_eff) * (2*SIDE_W)'(h_eff);
	assign range_bad = ((2*SIDE_W)'(start_q) >= cells) || ((2*SIDE_W)'(goal_q) >= cells) ||
		(start_q == goal_q);

	// neighbor k of the current center
	assign off_r   = nb_off_r(k_q);
	assign off_c   = nb_off_c(k_q);
	assign nr_s    = $signed({{(SIDE_W+1-RC_W){1'b0}}, ctr_row_q}) +
		$signed({{(SIDE_W-1){off_r[1]}}, off_r});
	assign nc_s    = $signed({{(SIDE_W+1-RC_W){1'b0}}, ctr_col_q}) +
		$signed({{(SIDE_W-1){off_c[1]}}, off_c});
	assign nb_in   = !nr_s[SIDE_W] && (nr_s[SIDE_W-1:0] < h_eff) &&
		!nc_s[SIDE_W] && (nc_s[SIDE_W-1:0] < w_eff);
	assign nr      = nr_s[RC_W-1:0];
	assign nc      = nc_s[RC_W-1:0];
	assign nb_diag = (off_r != 2'b00) && (off_c != 2'b00);
	assign nb_prod = (2*SIDE_W)'(nr) * (2*SIDE_W)'(w_eff);
	assign nb_idx  = nb_prod[CELL_W-1:0] + CELL_W'(nc);

	// cost of reaching the neighbor, saturated, and its f
	assign c_sum = {1'b0, g_cur_q} + {1'b0, (nb_diag_q ? DIAG_COST : STEP_COST)};
	assign c_new = (c_sum > {1'b0, COST_SAT}) ? COST_SAT : c_sum[COST_W-1:0];
	assign f_new = {1'b0, c_new} + F_W'(nb_h_q);

	assign exp_take  = free_rd_q && (cost_rd_q == COST_UNREACHED);
	assign walk_take = free_rd_q && (!nb_any_q || (cost_rd_q < best_cost_q));
	assign pop_take  = pv_s1 && !open_rd_q.removed && (!pop_any_q || (open_rd_q.f < pop_best_q.f));

	// path reads count from the start; the store holds the path goal first
	assign path_off = stored_len_q - LEN_W'(1) - {1'b0, path_index};

	// next state and memory controls
	always_comb begin
		state_d    = state_q;
		free_we    = 1'b0;
		free_waddr = cell_index;
		free_wdata = cell_free;
		mem_raddr  = nb_idx;
		cost_we    = 1'b0;
		cost_waddr = nb_idx_q;
		cost_wdata = c_new;
		open_we    = 1'b0;
		open_waddr = open_tail_q[CELL_W-1:0];
		open_wdata = '{removed: 1'b0, row: nb_row_q, col: nb_col_q, g: c_new, f: f_new};
		path_we    = 1'b0;
		path_waddr = walk_len_q[CELL_W-1:0];
		path_wdata = best_idx_q;
		path_raddr = path_off[CELL_W-1:0];
		res_en     = 1'b0;
		res_hit    = 1'b0;
		res_status = STAT_OK;
		res_len_en = 1'b0;
		res_len    = '0;
		case (state_q)
			S_CLR: begin
				free_we    = 1'b1;
				free_waddr = clr_q[CELL_W-1:0];
				free_wdata = 1'b0;
				if (clr_q == LEN_W'(MAX_CELLS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					case (op_t'(op))
						OP_WRITE: begin
							free_we = 1'b1;
							res_en  = 1'b1;
						end
						OP_SEARCH: state_d = S_DIV;
						OP_READ: begin
							res_en = 1'b1;
							if ({1'b0, path_index} < stored_len_q) res_hit = 1'b1;
							else res_status = STAT_NO_PATH;
						end
						default: res_en = 1'b1;
					endcase
				end
			end
			S_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(CELL_W - 1)) state_d = S_RANGE;
			end
			S_RANGE: begin
				if (range_bad) begin
					res_en = 1'b1; res_status = STAT_INVALID; res_len_en = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_FREE_S;
				end
			end
			S_FREE_S: begin
				mem_raddr = start_q;
				state_d   = S_FREE_G;
			end
			S_FREE_G: begin
				mem_raddr = goal_q;
				state_d   = S_FREE_CHK;
			end
			S_FREE_CHK: begin
				if (free_s_q && free_rd_q) begin
					state_d = S_NB_RD;
				end else begin
					res_en = 1'b1; res_status = STAT_INVALID; res_len_en = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_NB_RD: begin
				if (nb_in) state_d = S_NB_EV;
				else if (k_q == NB_LAST) state_d = S_NB_END;
			end
			S_NB_EV: begin
				if (mode_q == M_EXPAND && exp_take) begin
					cost_we = 1'b1;
					open_we = 1'b1;
				end
				state_d = (k_q == NB_LAST) ? S_NB_END : S_NB_RD;
			end
			S_NB_END: begin
				case (mode_q)
					M_CHK_GOAL: begin
						if (nb_any_q) begin
							state_d = S_NB_RD;
						end else begin
							res_en = 1'b1; res_status = STAT_INVALID; res_len_en = 1'b1;
							state_d = S_IDLE;
						end
					end
					M_CHK_START: begin
						if (nb_any_q) begin
							state_d = S_CCLR;
						end else begin
							res_en = 1'b1; res_status = STAT_INVALID; res_len_en = 1'b1;
							state_d = S_IDLE;
						end
					end
					M_EXPAND: begin
						if (goal_hit_q) begin
							state_d = S_WALK_INIT;
						end else if (open_live_q == '0) begin
							res_en = 1'b1; res_status = STAT_NO_PATH; res_len_en = 1'b1;
							state_d = S_IDLE;
						end else begin
							state_d = S_POP_RD;
						end
					end
					default: begin
						if (!nb_any_q) begin
							res_en = 1'b1; res_status = STAT_FOUND;
							res_len_en = 1'b1; res_len = walk_len_q;
							state_d = S_IDLE;
						end else begin
							path_we = 1'b1;
							if (best_idx_q == start_q ||
								walk_len_q + LEN_W'(1) == LEN_W'(MAX_CELLS)) begin
								res_en = 1'b1; res_status = STAT_FOUND;
								res_len_en = 1'b1; res_len = walk_len_q + LEN_W'(1);
								state_d = S_IDLE;
							end else begin
								state_d = S_NB_RD;
							end
						end
					end
				endcase
			end
			S_CCLR: begin
				cost_we    = 1'b1;
				cost_waddr = clr_q[CELL_W-1:0];
				cost_wdata = COST_UNREACHED;
				if (clr_q == LEN_W'(MAX_CELLS - 1)) state_d = S_SEED;
			end
			S_SEED: begin
				cost_we    = 1'b1;
				cost_waddr = start_q;
				cost_wdata = '0;
				open_we    = 1'b1;
				open_waddr = '0;
				open_wdata = '{removed: 1'b0, row: s_row_q, col: s_col_q, g: '0,
					f: F_W'(heur(s_row_q, s_col_q, g_row_q, g_col_q))};
				state_d    = S_POP_RD;
			end
			S_POP_RD: begin
				if ({1'b0, scan_q} == open_tail_q - LEN_W'(1)) state_d = S_POP_LAST;
			end
			S_POP_LAST: state_d = S_POP_TAKE;
			S_POP_TAKE: begin
				open_we    = 1'b1;
				open_waddr = pop_idx_q;
				open_wdata = pop_best_q;
				open_wdata.removed = 1'b1;
				state_d    = S_NB_RD;
			end
			S_WALK_INIT: begin
				path_we    = 1'b1;
				path_waddr = '0;
				path_wdata = goal_q;
				state_d    = S_NB_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register and control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_q        <= '0;
			done_q       <= 1'b0;
			rd_hit_q     <= 1'b0;
			status_q     <= STAT_OK;
			stored_len_q <= '0;
			w_q          <= SIDE_MAX;
			h_q          <= SIDE_MAX;
			open_tail_q  <= '0;
			open_live_q  <= '0;
		end else begin
			state_q  <= state_d;
			clr_q    <= (state_q == S_CLR || state_q == S_CCLR) ? clr_q + LEN_W'(1) : '0;
			done_q   <= res_en;
			rd_hit_q <= res_hit;
			if (res_en) status_q <= res_status;
			if (res_len_en) stored_len_q <= res_len;
			if (wr_en) begin
				case (wr_index)
					CFG_GRID_WIDTH:  w_q <= wr_data;
					CFG_GRID_HEIGHT: h_q <= wr_data;
					default: ;
				endcase
			end
			// open-list fill and live counts
			if (state_q == S_SEED) begin
				open_tail_q <= LEN_W'(1);
				open_live_q <= LEN_W'(1);
			end else if (state_q == S_NB_EV && mode_q == M_EXPAND && exp_take) begin
				open_tail_q <= open_tail_q + LEN_W'(1);
				open_live_q <= open_live_q + LEN_W'(1);
			end else if (state_q == S_POP_TAKE) begin
				open_live_q <= open_live_q - LEN_W'(1);
			end
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				start_q   <= start_cell;
				goal_q    <= goal_cell;
				div_cnt_q <= '0;
				s_rem_q   <= '0;
				g_rem_q   <= '0;
				s_quo_q   <= start_cell;
				g_quo_q   <= goal_cell;
			end
			S_DIV: begin
				s_rem_q   <= s_rem_n;
				g_rem_q   <= g_rem_n;
				s_quo_q   <= {s_quo_q[CELL_W-2:0], s_bit};
				g_quo_q   <= {g_quo_q[CELL_W-2:0], g_bit};
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			S_RANGE: begin
				s_row_q <= s_quo_q[RC_W-1:0];
				s_col_q <= s_rem_q[RC_W-1:0];
				g_row_q <= g_quo_q[RC_W-1:0];
				g_col_q <= g_rem_q[RC_W-1:0];
			end
			S_FREE_G: free_s_q <= free_rd_q;
			S_FREE_CHK: begin
				mode_q    <= M_CHK_GOAL;
				ctr_row_q <= g_row_q;
				ctr_col_q <= g_col_q;
				k_q       <= '0;
				nb_any_q  <= 1'b0;
			end
			S_NB_RD: begin
				nb_idx_q  <= nb_idx;
				nb_row_q  <= nr;
				nb_col_q  <= nc;
				nb_diag_q <= nb_diag;
				nb_h_q    <= heur(nr, nc, g_row_q, g_col_q);
				if (!nb_in && k_q != NB_LAST) k_q <= k_q + NB_W'(1);
			end
			S_NB_EV: begin
				case (mode_q)
					M_EXPAND: begin
						if (exp_take && nb_idx_q == goal_q) goal_hit_q <= 1'b1;
					end
					M_WALK: begin
						if (walk_take) begin
							best_idx_q  <= nb_idx_q;
							best_row_q  <= nb_row_q;
							best_col_q  <= nb_col_q;
							best_cost_q <= cost_rd_q;
							nb_any_q    <= 1'b1;
						end
					end
					default: begin
						if (free_rd_q) nb_any_q <= 1'b1;
					end
				endcase
				if (k_q != NB_LAST) k_q <= k_q + NB_W'(1);
			end
			S_NB_END: begin
				case (mode_q)
					M_CHK_GOAL: begin
						mode_q    <= M_CHK_START;
						ctr_row_q <= s_row_q;
						ctr_col_q <= s_col_q;
						k_q       <= '0;
						nb_any_q  <= 1'b0;
					end
					M_EXPAND: begin
						scan_q    <= '0;
						pv_s1     <= 1'b0;
						pop_any_q <= 1'b0;
					end
					M_WALK: begin
						walk_len_q <= walk_len_q + LEN_W'(1);
						ctr_row_q  <= best_row_q;
						ctr_col_q  <= best_col_q;
						k_q        <= '0;
						nb_any_q   <= 1'b0;
					end
					default: ;
				endcase
			end
			S_SEED: begin
				goal_hit_q <= 1'b0;
				scan_q     <= '0;
				pv_s1      <= 1'b0;
				pop_any_q  <= 1'b0;
			end
			S_POP_RD, S_POP_LAST: begin
				// compare the slot read last cycle while the next one is fetched
				scan_q  <= scan_q + CELL_W'(1);
				pidx_s1 <= scan_q;
				pv_s1   <= (state_q == S_POP_RD);
				if (pop_take) begin
					pop_best_q <= open_rd_q;
					pop_idx_q  <= pidx_s1;
					pop_any_q  <= 1'b1;
				end
			end
			S_POP_TAKE: begin
				mode_q    <= M_EXPAND;
				ctr_row_q <= pop_best_q.row;
				ctr_col_q <= pop_best_q.col;
				g_cur_q   <= pop_best_q.g;
				k_q       <= '0;
			end
			S_WALK_INIT: begin
				walk_len_q <= LEN_W'(1);
				mode_q     <= M_WALK;
				ctr_row_q  <= g_row_q;
				ctr_col_q  <= g_col_q;
				k_q        <= '0;
				nb_any_q   <= 1'b0;
			end
			default: ;
		endcase
	end

	// free map: one write, one registered read
	always_ff @(posedge clk) begin
		if (free_we) free_mem[free_waddr] <= free_wdata;
		free_rd_q <= free_mem[mem_raddr];
	end

	// cost to reach, read at the same address as the free map
	always_ff @(posedge clk) begin
		if (cost_we) cost_mem[cost_waddr] <= cost_wdata;
		cost_rd_q <= cost_mem[mem_raddr];
	end

	// open list slots
	always_ff @(posedge clk) begin
		if (open_we) open_mem[open_waddr] <= open_wdata;
		open_rd_q <= open_mem[scan_q];
	end

	// stored path, goal at slot 0
	always_ff @(posedge clk) begin
		if (path_we) path_mem[path_waddr] <= path_wdata;
		path_rd_q <= path_mem[path_raddr];
	end

	// result ports
	assign done        = done_q;
	assign status      = status_q;
	assign path_length = stored_len_q;
	assign path_cell   = rd_hit_q ? path_rd_q : '0;

	`include "grid_astar_path_search_assert.svh"

	`GAPS_ASSERT_IMP(a_done_not_busy, done, !busy, "result strobe while busy")
	`GAPS_ASSERT_NEXT(a_read_answers, start && !busy && (op == OP_READ), done && (status == STAT_OK || status == STAT_NO_PATH), "read request without result")
	`GAPS_ASSERT_IMP(a_live_le_tail, 1'b1, open_live_q <= open_tail_q, "open list live count above fill")
	`GAPS_ASSERT_IMP(a_found_len, done && (status == STAT_FOUND), (path_length >= LEN_W'(2)) && (path_length <= LEN_W'(MAX_CELLS)), "found path length out of range")

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the grid_astar_path_search block.
// Depends on gaps_pkg and the block's RTL; no other files are read.
`timescale 1ns / 100ps

module tb;
	import gaps_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int              NO_COST   = 65535;
	localparam int              COST_TOP  = 65534;

	typedef struct packed {
		logic [1:0]       st;
		logic [LEN_W-1:0] len;
		logic [CELL_W-1:0] pcell;
	} route_result_t;

	// one directed request; known marks a typed-in answer
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [CELL_W-1:0] ci;
		logic              cf;
		logic [CELL_W-1:0] sc;
		logic [CELL_W-1:0] gc;
		logic [CELL_W-1:0] pi;
		logic              known;
		logic [1:0]        st;
		logic [LEN_W-1:0]  len;
		logic [CELL_W-1:0] pcell;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [SIDE_W-1:0]    wr_data = '0;
	logic [OP_W-1:0]      op = '0;
	logic [CELL_W-1:0]    cell_index = '0;
	logic                 cell_free = 1'b0;
	logic [CELL_W-1:0]    start_cell = '0;
	logic [CELL_W-1:0]    goal_cell = '0;
	logic [CELL_W-1:0]    path_index = '0;
	logic                 done;
	logic [1:0]           status;
	logic [LEN_W-1:0]     path_length;
	logic [CELL_W-1:0]    path_cell;

	// shadow of the block's state
	bit                fmap [MAX_CELLS];
	int                reach_cost [MAX_CELLS];
	int                route [MAX_CELLS];
	int                route_len;
	logic [SIDE_W-1:0] width_reg;
	logic [SIDE_W-1:0] height_reg;

	route_result_t pending_results [$];
	int            mismatches;
	int            n_found, n_nopath, n_invalid, n_reads, n_writes;

	grid_astar_path_search dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.op(op), .cell_index(cell_index), .cell_free(cell_free),
		.start_cell(start_cell), .goal_cell(goal_cell), .path_index(path_index),
		.done(done), .status(status), .path_length(path_length), .path_cell(path_cell)
	);

	always #5 clk = ~clk;

	function automatic int side_of(input logic [SIDE_W-1:0] v);
		if (v == 0) return 1;
		if (v > SIDE_MAX) return int'(SIDE_MAX);
		return int'(v);
	endfunction

	function automatic int manhattan10(input int a, input int b, input int w);
		int dr, dc;
		dr = a / w - b / w;
		dc = a % w - b % w;
		if (dr < 0) dr = -dr;
		if (dc < 0) dc = -dc;
		return (dr + dc) * 10;
	endfunction

	// free 8-neighbors, row-major over the window
	function automatic int free_nbrs(input int cidx, input int w, input int h,
			output int nb [8], output bit dg [8]);
		int n, row, col, r, c, idx;
		n = 0;
		row = cidx / w;
		col = cidx % w;
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				r = row + dr;
				c = col + dc;
				if (dr == 0 && dc == 0) continue;
				if (r < 0 || c < 0 || r >= h || c >= w) continue;
				idx = r * w + c;
				if (idx >= MAX_CELLS || !fmap[idx]) continue;
				nb[n] = idx;
				dg[n] = (dr != 0 && dc != 0);
				n++;
			end
		end
		return n;
	endfunction

	// A* search plus path rebuild; returns the status code
	function automatic status_t plan_route(input int s, input int g);
		int w, h, n, cur, k, c, best, len, t;
		int nb [8];
		bit dg [8];
		int oq_cell [$];
		int oq_f [$];
		w = side_of(width_reg);
		h = side_of(height_reg);
		if (s >= w * h || g >= w * h || s == g || !fmap[s] || !fmap[g] ||
				free_nbrs(g, w, h, nb, dg) == 0 || free_nbrs(s, w, h, nb, dg) == 0) begin
			route_len = 0;
			return STAT_INVALID;
		end
		foreach (reach_cost[i]) reach_cost[i] = NO_COST;
		reach_cost[s] = 0;
		oq_cell.insert(oq_cell.size(), s);
		oq_f.insert(oq_f.size(), manhattan10(s, g, w));
		while (oq_cell.size() > 0 && reach_cost[g] == NO_COST) begin
			// lowest f, first inserted wins ties
			k = 0;
			for (int i = 1; i < oq_cell.size(); i++)
				if (oq_f[i] < oq_f[k]) k = i;
			cur = oq_cell[k];
			oq_cell.delete(k);
			oq_f.delete(k);
			n = free_nbrs(cur, w, h, nb, dg);
			for (int i = 0; i < n; i++) begin
				if (reach_cost[nb[i]] != NO_COST) continue;
				c = reach_cost[cur] + (dg[i] ? 14 : 10);
				if (c > COST_TOP) c = COST_TOP;
				reach_cost[nb[i]] = c;
				if (oq_cell.size() < MAX_CELLS) begin
					oq_cell.insert(oq_cell.size(), nb[i]);
					oq_f.insert(oq_f.size(), c + manhattan10(nb[i], g, w));
				end
			end
		end
		if (reach_cost[g] == NO_COST) begin
			route_len = 0;
			return STAT_NO_PATH;
		end
		// walk back along least cost, then reverse
		len = 0;
		cur = g;
		route[len++] = cur;
		while (cur != s && len < MAX_CELLS) begin
			n = free_nbrs(cur, w, h, nb, dg);
			if (n == 0) break;
			best = 0;
			for (int i = 1; i < n; i++)
				if (reach_cost[nb[i]] < reach_cost[nb[best]]) best = i;
			cur = nb[best];
			route[len++] = cur;
		end
		for (int i = 0; i < len / 2; i++) begin
			t = route[i];
			route[i] = route[len - 1 - i];
			route[len - 1 - i] = t;
		end
		route_len = len;
		return STAT_FOUND;
	endfunction

	// apply one request to the shadow state and return the expected result
	function automatic route_result_t planner_step(input logic [OP_W-1:0] o,
			input logic [CELL_W-1:0] ci, input logic cf, input logic [CELL_W-1:0] sc,
			input logic [CELL_W-1:0] gc, input logic [CELL_W-1:0] pi);
		route_result_t r;
		status_t s;
		r = '0;
		case (o)
			OP_WRITE: begin
				fmap[ci] = cf;
				n_writes++;
			end
			OP_SEARCH: begin
				s = plan_route(int'(sc), int'(gc));
				r.st = s;
				if (s == STAT_FOUND) n_found++;
				else if (s == STAT_NO_PATH) n_nopath++;
				else n_invalid++;
			end
			OP_READ: begin
				n_reads++;
				if (int'(pi) < route_len) r.pcell = CELL_W'(route[pi]);
				else r.st = STAT_NO_PATH;
			end
			default: ;
		endcase
		r.len = LEN_W'(route_len);
		return r;
	endfunction

	// drive one request, hold it until accepted, then record the expectation
	task automatic send_request(input logic [OP_W-1:0] o, input logic [CELL_W-1:0] ci,
			input logic cf, input logic [CELL_W-1:0] sc, input logic [CELL_W-1:0] gc,
			input logic [CELL_W-1:0] pi, input bit known, input route_result_t typed);
		int gap;
		route_result_t r;
		case ($urandom_range(0, 19))
			0:             gap = $urandom_range(10, 40);
			1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
			default:       gap = 0;
		endcase
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		op         <= o;
		cell_index <= ci;
		cell_free  <= cf;
		start_cell <= sc;
		goal_cell  <= gc;
		path_index <= pi;
		do @(posedge clk); while (busy);
		r = planner_step(o, ci, cf, sc, gc, pi);
		pending_results.insert(pending_results.size(), known ? typed : r);
	endtask

	task automatic rand_request(input logic [OP_W-1:0] o, input logic [CELL_W-1:0] ci,
			input logic cf, input logic [CELL_W-1:0] sc, input logic [CELL_W-1:0] gc,
			input logic [CELL_W-1:0] pi);
		send_request(o, ci, cf, sc, gc, pi, 1'b0, '0);
	endtask

	// grid size change, only once the block has drained
	task automatic set_grid(input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h);
		start <= 1'b0;
		while (pending_results.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
		while (busy) @(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= CFG_GRID_WIDTH;
		wr_data  <= w;
		@(posedge clk);
		wr_index <= CFG_GRID_HEIGHT;
		wr_data  <= h;
		@(posedge clk);
		wr_en <= 1'b0;
		width_reg  = w;
		height_reg = h;
	endtask

	// result checker
	always @(posedge clk) begin
		route_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing pending: st=%0d len=%0d cell=%0d",
						$realtime, status, path_length, path_cell);
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st || path_length !== e.len || path_cell !== e.pcell) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch exp st=%0d len=%0d cell=%0d got st=%0d len=%0d cell=%0d",
							$realtime, e.st, e.len, e.pcell, status, path_length, path_cell);
				end
			end
		end
	end

	initial begin
		#50ms;
		$display("== FAIL ==");
		$finish;
	end

	// directed requests at the 64 x 64 reset size
	dir_row_t dir_tab [] = '{
		// read with nothing stored
		'{OP_READ,   12'd0,    1'b0, 12'd0, 12'd0,    12'd0,    1'b1, STAT_NO_PATH, 13'd0, 12'd0},
		// all cells blocked
		'{OP_SEARCH, 12'd0,    1'b0, 12'd0, 12'd4095, 12'd0,    1'b1, STAT_INVALID, 13'd0, 12'd0},
		// unused op with every field at its top
		'{OP_UNUSED, 12'd4095, 1'b1, 12'd4095, 12'd4095, 12'd4095, 1'b1, STAT_OK, 13'd0, 12'd0},
		'{OP_WRITE,  12'd4095, 1'b1, 12'd0, 12'd0,    12'd0,    1'b1, STAT_OK,      13'd0, 12'd0},
		'{OP_WRITE,  12'd0,    1'b1, 12'd0, 12'd0,    12'd0,    1'b1, STAT_OK,      13'd0, 12'd0},
		'{OP_WRITE,  12'd1,    1'b1, 12'd0, 12'd0,    12'd0,    1'b1, STAT_OK,      13'd0, 12'd0},
		'{OP_WRITE,  12'd64,   1'b1, 12'd0, 12'd0,    12'd0,    1'b1, STAT_OK,      13'd0, 12'd0},
		'{OP_WRITE,  12'd65,   1'b1, 12'd0, 12'd0,    12'd0,    1'b1, STAT_OK,      13'd0, 12'd0},
		// start equals goal
		'{OP_SEARCH, 12'd0,    1'b0, 12'd0, 12'd0,    12'd0,    1'b1, STAT_INVALID, 13'd0, 12'd0},
		// goal free but walled in
		'{OP_SEARCH, 12'd0,    1'b0, 12'd0, 12'd4095, 12'd0,    1'b1, STAT_INVALID, 13'd0, 12'd0},
		'{OP_SEARCH, 12'd0,    1'b0, 12'd0, 12'd65,   12'd0,    1'b0, STAT_OK,      13'd0, 12'd0},
		'{OP_READ,   12'd0,    1'b0, 12'd0, 12'd0,    12'd0,    1'b0, STAT_OK,      13'd0, 12'd0},
		'{OP_READ,   12'd0,    1'b0, 12'd0, 12'd0,    12'd1,    1'b0, STAT_OK,      13'd0, 12'd0},
		'{OP_READ,   12'd0,    1'b0, 12'd0, 12'd0,    12'd2,    1'b0, STAT_OK,      13'd0, 12'd0},
		'{OP_READ,   12'd0,    1'b0, 12'd0, 12'd0,    12'd4095, 1'b0, STAT_OK,      13'd0, 12'd0},
		'{OP_SEARCH, 12'd0,    1'b0, 12'd1, 12'd64,   12'd0,    1'b0, STAT_OK,      13'd0, 12'd0},
		// goal blocked
		'{OP_WRITE,  12'd65,   1'b0, 12'd0, 12'd0,    12'd0,    1'b0, STAT_OK,      13'd0, 12'd0},
		'{OP_SEARCH, 12'd0,    1'b0, 12'd0, 12'd65,   12'd0,    1'b1, STAT_INVALID, 13'd0, 12'd0},
		// two separate islands
		'{OP_WRITE,  12'd4031, 1'b1, 12'd0, 12'd0,    12'd0,    1'b0, STAT_OK,      13'd0, 12'd0},
		'{OP_SEARCH, 12'd0,    1'b0, 12'd0, 12'd4095, 12'd0,    1'b1, STAT_NO_PATH, 13'd0, 12'd0},
		'{OP_READ,   12'd0,    1'b0, 12'd0, 12'd0,    12'd0,    1'b1, STAT_NO_PATH, 13'd0, 12'd0}
	};

	// stimulus
	initial begin
		int w, h, sw, sh, kind, sc, gc, pi, cnt;
		logic [SIDE_W-1:0] sizes [20];
		foreach (fmap[i]) fmap[i] = 1'b0;
		route_len  = 0;
		width_reg  = SIDE_MAX;
		height_reg = SIDE_MAX;
		mismatches = 0;
		n_found = 0; n_nopath = 0; n_invalid = 0; n_reads = 0; n_writes = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i])
			send_request(dir_tab[i].op, dir_tab[i].ci, dir_tab[i].cf, dir_tab[i].sc,
				dir_tab[i].gc, dir_tab[i].pi, dir_tab[i].known,
				'{dir_tab[i].st, dir_tab[i].len, dir_tab[i].pcell});

		// size pairs: a fixed list with clamped extremes, then small random grids
		sizes = '{7'd0, 7'd5, 7'd127, 7'd1, 7'd1, 7'd64, 7'd64, 7'd64, 7'd3, 7'd3,
			7'd8, 7'd8, 7'd2, 7'd2, 7'd6, 7'd7, 7'd0, 7'd0, 7'd65, 7'd6};
		for (int p = 0; p < 14; p++) begin
			if (p < 10) set_grid(sizes[2 * p], sizes[2 * p + 1]);
			else set_grid(7'($urandom_range(2, 9)), 7'($urandom_range(2, 9)));
			w  = side_of(width_reg);
			h  = side_of(height_reg);
			sw = (w < 8) ? w : 8;
			sh = (h < 8) ? h : 8;
			// wipe whatever earlier phases left free
			for (int i = 0; i < MAX_CELLS; i++)
				if (fmap[i]) rand_request(OP_WRITE, 12'(i), 1'b0, 12'($urandom),
					12'($urandom), 12'($urandom));
			// lay out a working area in the top-left corner
			for (int r = 0; r < sh; r++)
				for (int c = 0; c < sw; c++)
					rand_request(OP_WRITE, 12'(r * w + c), ($urandom_range(0, 3) != 0),
						12'($urandom), 12'($urandom), 12'($urandom));
			cnt = 0;
			while (cnt < 20) begin
				kind = $urandom_range(0, 99);
				sc = ($urandom_range(0, 4) != 0) ?
					$urandom_range(0, sh - 1) * w + $urandom_range(0, sw - 1) : $urandom;
				gc = ($urandom_range(0, 4) != 0) ?
					$urandom_range(0, sh - 1) * w + $urandom_range(0, sw - 1) : $urandom;
				pi = (route_len > 0 && $urandom_range(0, 4) != 0) ?
					$urandom_range(0, route_len - 1) : $urandom;
				if (kind < 18)
					rand_request(OP_SEARCH, 12'($urandom), 1'($urandom), 12'(sc), 12'(gc),
						12'($urandom));
				else if (kind < 55)
					rand_request(OP_READ, 12'($urandom), 1'($urandom), 12'($urandom),
						12'($urandom), 12'(pi));
				else if (kind < 88)
					rand_request(OP_WRITE, 12'(sc), 1'($urandom), 12'($urandom),
						12'($urandom), 12'($urandom));
				else if (kind < 95)
					rand_request(OP_WRITE, 12'($urandom), 1'($urandom), 12'($urandom),
						12'($urandom), 12'($urandom));
				else
					rand_request(OP_UNUSED, 12'($urandom), 1'($urandom), 12'($urandom),
						12'($urandom), 12'($urandom));
				cnt++;
			end
		end

		start <= 1'b0;
		cnt = 0;
		while (pending_results.size() > 0 && cnt < 200000) begin
			@(posedge clk);
			cnt++;
		end
		repeat (50) @(posedge clk);
		$display("Searches: %0d found, %0d no path, %0d rejected; %0d reads, %0d cell writes",
			n_found, n_nopath, n_invalid, n_reads, n_writes);
		$display("Grid sizes from 1 to 64 per side, clamped settings included; %0d mismatches",
			mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
